@@ rtl/core/dtr_pkg.sv @@
// Types, constants and helper functions shared by the divider timer modules.
package dtr_pkg;

    localparam logic [1:0]  OP_TICK  = 2'd0;
    localparam logic [1:0]  OP_READ  = 2'd1;
    localparam logic [1:0]  OP_WRITE = 2'd2;

    localparam logic [1:0]  SEL_DIV  = 2'd0;
    localparam logic [1:0]  SEL_CNT  = 2'd1;
    localparam logic [1:0]  SEL_MOD  = 2'd2;
    localparam logic [1:0]  SEL_CTL  = 2'd3;

    localparam logic [1:0]  RATE_1024 = 2'd0;
    localparam logic [1:0]  RATE_16   = 2'd1;
    localparam logic [1:0]  RATE_64   = 2'd2;
    localparam logic [1:0]  RATE_256  = 2'd3;

    localparam logic [2:0]  RELOAD_DELAY = 3'd4;
    localparam logic [15:0] DIV_RESET    = 16'hABD4;
    localparam logic [7:0]  CTL_RESET    = 8'hF8;
    localparam int          CTL_EN_BIT   = 2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] cycles;
        logic [1:0] reg_sel;
        logic [7:0] wdata;
    } req_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       timer_irq;
    } rsp_t;

    function automatic logic gate_tap(input logic [15:0] div, input logic [1:0] rate);
        logic tap;
        case (rate)
            RATE_1024: tap = div[9];
            RATE_16:   tap = div[3];
            RATE_64:   tap = div[5];
            RATE_256:  tap = div[7];
            default:   tap = 1'b0;
        endcase
        return tap;
    endfunction

    function automatic logic [4:0] tick_steps(input logic [15:0] old_div,
                                              input logic [15:0] new_div,
                                              input logic [1:0]  rate);
        logic [5:0]  d10;
        logic [11:0] d4;
        logic [9:0]  d6;
        logic [7:0]  d8;
        logic [4:0]  steps;
        d10 = new_div[15:10] - old_div[15:10];
        d4  = new_div[15:4]  - old_div[15:4];
        d6  = new_div[15:6]  - old_div[15:6];
        d8  = new_div[15:8]  - old_div[15:8];
        case (rate)
            RATE_1024: steps = d10[4:0];
            RATE_16:   steps = d4[4:0];
            RATE_64:   steps = d6[4:0];
            RATE_256:  steps = d8[4:0];
            default:   steps = 5'd0;
        endcase
        return steps;
    endfunction

endpackage

@@ rtl/core/divider_timer_with_reload.sv @@
// Top level of the divider timer with delayed reload.
//
//   channel   direction   handshake               payload
//   request   in          req_valid / req_stall   req (opcode, cycles, reg_sel, wdata)
//   response  out         rsp_valid / rsp_stall   rsp (rdata, timer_irq)
//
// One request is taken every clock while req_stall is low; its response passes through the input and result registers.
// The timer state updates as the request leaves the input register.
// Reset clears both valid bits and loads the timer registers with their power-on values.
// A stalled response holds the result register, then the input register, then req_stall.
module divider_timer_with_reload (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dtr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dtr_pkg::rsp_t rsp
);
    import dtr_pkg::*;

    logic s1_valid;
    logic s1_stall;
    req_t s1_req;
    rsp_t s1_rsp;

    dtr_input_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .s1_valid  (s1_valid),
        .s1_req    (s1_req),
        .s1_stall  (s1_stall)
    );

    dtr_engine u_eng (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_valid && !s1_stall),
        .s1_req (s1_req),
        .s1_rsp (s1_rsp)
    );

    dtr_output_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_rsp    (s1_rsp),
        .s1_stall  (s1_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

@@ rtl/core/dtr_input_stage.sv @@
// Input register: captures one request per cycle and holds it while downstream stalls.
module dtr_input_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dtr_pkg::req_t req,
    output logic          s1_valid,
    output dtr_pkg::req_t s1_req,
    input  logic          s1_stall
);
    import dtr_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    req_t req_next;

    assign req_stall = valid_reg && s1_stall;

    always_comb
    begin
        valid_next = valid_reg;
        req_next   = req_reg;
        if (!req_stall)
        begin
            valid_next = req_valid;
            req_next   = req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign s1_valid = valid_reg;
    assign s1_req   = req_reg;

endmodule

@@ rtl/core/dtr_engine.sv @@
// Timer state registers and the single-pass update for tick, read and write requests.
module dtr_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  dtr_pkg::req_t s1_req,
    output dtr_pkg::rsp_t s1_rsp
);
    import dtr_pkg::*;

    logic [15:0] div_reg, div_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  mod_reg, mod_next;
    logic [7:0]  ctl_reg, ctl_next;
    logic [2:0]  rw_reg,  rw_next;
    logic        jr_reg,  jr_next;

    logic [15:0] div_sum;
    logic [4:0]  steps;
    logic [7:0]  cnt_mid;
    logic [2:0]  rw_mid;
    logic [8:0]  cnt_sum;
    logic        gate_before;
    logic        gate_after;

    assign div_sum     = div_reg + {8'd0, s1_req.cycles};
    assign steps       = tick_steps(div_reg, div_sum, ctl_reg[1:0]);
    assign gate_before = ctl_reg[CTL_EN_BIT] && gate_tap(div_reg, ctl_reg[1:0]);
    assign gate_after  = (s1_req.reg_sel == SEL_CTL)
                         && s1_req.wdata[CTL_EN_BIT] && gate_tap(div_reg, ctl_reg[1:0]);

    always_comb
    begin
        div_next         = div_reg;
        cnt_next         = cnt_reg;
        mod_next         = mod_reg;
        ctl_next         = ctl_reg;
        rw_next          = rw_reg;
        jr_next          = jr_reg;
        cnt_mid          = cnt_reg;
        rw_mid           = rw_reg;
        cnt_sum          = 9'd0;
        s1_rsp.rdata     = 8'd0;
        s1_rsp.timer_irq = 1'b0;
        if (fire)
        begin
            case (s1_req.opcode)
                OP_TICK:
                begin
                    div_next = div_sum;
                    jr_next  = 1'b0;
                    if (rw_reg != 3'd0)
                    begin
                        if (s1_req.cycles >= {5'd0, rw_reg})
                        begin
                            cnt_mid          = mod_reg;
                            rw_mid           = 3'd0;
                            jr_next          = 1'b1;
                            s1_rsp.timer_irq = 1'b1;
                        end
                        else
                        begin
                            rw_mid = rw_reg - s1_req.cycles[2:0];
                        end
                    end
                    cnt_next = cnt_mid;
                    rw_next  = rw_mid;
                    if (ctl_reg[CTL_EN_BIT] && (steps != 5'd0))
                    begin
                        cnt_sum = {1'b0, cnt_mid} + {4'd0, steps};
                        if (cnt_sum[8])
                        begin
                            cnt_next = 8'd0;
                            rw_next  = RELOAD_DELAY;
                        end
                        else
                        begin
                            cnt_next = cnt_sum[7:0];
                        end
                    end
                end
                OP_READ:
                begin
                    case (s1_req.reg_sel)
                        SEL_DIV: s1_rsp.rdata = div_reg[15:8];
                        SEL_CNT: s1_rsp.rdata = cnt_reg;
                        SEL_MOD: s1_rsp.rdata = mod_reg;
                        default: s1_rsp.rdata = ctl_reg;
                    endcase
                end
                OP_WRITE:
                begin
                    case (s1_req.reg_sel)
                        SEL_CNT:
                        begin
                            if (!jr_reg)
                            begin
                                cnt_next = s1_req.wdata;
                                rw_next  = 3'd0;
                            end
                        end
                        SEL_MOD:
                        begin
                            mod_next = s1_req.wdata;
                            if (jr_reg)
                            begin
                                cnt_next = s1_req.wdata;
                            end
                        end
                        default:
                        begin
                            if (s1_req.reg_sel == SEL_DIV)
                            begin
                                div_next = 16'd0;
                            end
                            else
                            begin
                                ctl_next = s1_req.wdata;
                            end
                            if (gate_before && !gate_after)
                            begin
                                cnt_next = cnt_reg + 8'd1;
                                if (cnt_reg == 8'hFF)
                                begin
                                    rw_next = RELOAD_DELAY;
                                end
                            end
                        end
                    endcase
                end
                default:
                begin
                    div_next = div_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= DIV_RESET;
            cnt_reg <= 8'd0;
            mod_reg <= 8'd0;
            ctl_reg <= CTL_RESET;
            rw_reg  <= 3'd0;
            jr_reg  <= 1'b0;
        end
        else
        begin
            div_reg <= div_next;
            cnt_reg <= cnt_next;
            mod_reg <= mod_next;
            ctl_reg <= ctl_next;
            rw_reg  <= rw_next;
            jr_reg  <= jr_next;
        end
    end

endmodule

@@ rtl/core/dtr_output_stage.sv @@
// Result register: holds a finished result until the downstream side takes it.
module dtr_output_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s1_valid,
    input  dtr_pkg::rsp_t s1_rsp,
    output logic          s1_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dtr_pkg::rsp_t rsp
);
    import dtr_pkg::*;

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    assign s1_stall = valid_reg && rsp_stall;

    always_comb
    begin
        valid_next = valid_reg;
        rsp_next   = rsp_reg;
        if (!s1_stall)
        begin
            valid_next = s1_valid;
            rsp_next   = s1_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/dtr_checker.sv @@
// Port-level checks for the divider timer and the bind that attaches them.
module dtr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input dtr_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input dtr_pkg::rsp_t rsp
);
    import dtr_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed under stall");

    a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.timer_irq |-> rsp.rdata == 8'd0)
        else $error("interrupt response carries read data");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled while response side is free");

    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
        else $error("response without a matching request");

endmodule

bind divider_timer_with_reload dtr_checker u_dtr_checker (.*);

@@ verif/timer_checker.sv @@
// Response checker for the divider timer: tracks timer state from requests and compares responses.
`timescale 1ns / 1ps
module timer_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  dtr_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  dtr_pkg::rsp_t rsp,
    output int            fail_cnt,
    output int            pending,
    output int            rsp_cnt,
    output int            irq_cnt
);
    import dtr_pkg::*;

    logic [15:0] div_q;
    logic [7:0]  cnt_q;
    logic [7:0]  mod_q;
    logic [7:0]  ctl_q;
    logic [2:0]  wait_q;
    logic        reloaded_q;

    rsp_t expected_rsp_q[$];
    rsp_t want;
    int   fails;
    int   checked;
    int   irqs;

    function automatic int rate_shift(input logic [1:0] rate);
        int sh;
        case (rate)
            RATE_1024: sh = 10;
            RATE_16:   sh = 4;
            RATE_64:   sh = 6;
            default:   sh = 8;
        endcase
        return sh;
    endfunction

    function automatic logic gate_level(input logic [15:0] div, input logic [7:0] ctl,
                                        input logic [1:0] rate);
        return ctl[CTL_EN_BIT] & div[rate_shift(rate) - 1];
    endfunction

    function automatic void count_falling(input logic was, input logic now);
        if (was && !now)
        begin
            cnt_q = cnt_q + 8'd1;
            if (cnt_q == 8'd0)
                wait_q = RELOAD_DELAY;
        end
    endfunction

    function automatic rsp_t timer_step(input req_t r);
        rsp_t        o;
        logic [15:0] old_div;
        logic [1:0]  rate;
        logic        was;
        int          sh;
        int          steps;
        o = '0;
        case (r.opcode)
            OP_TICK:
            begin
                old_div = div_q;
                div_q = div_q + 16'(r.cycles);
                reloaded_q = 1'b0;
                if (wait_q != 3'd0)
                begin
                    if (r.cycles >= wait_q)
                    begin
                        cnt_q = mod_q;
                        o.timer_irq = 1'b1;
                        wait_q = 3'd0;
                        reloaded_q = 1'b1;
                    end
                    else
                        wait_q = wait_q - 3'(r.cycles);
                end
                if (ctl_q[CTL_EN_BIT])
                begin
                    sh = rate_shift(ctl_q[1:0]);
                    steps = ((int'(div_q) >> sh) - (int'(old_div) >> sh))
                            & ((32'h10000 >> sh) - 1);
                    if (steps > 0)
                    begin
                        if (int'(cnt_q) + steps > 255)
                        begin
                            cnt_q = 8'd0;
                            wait_q = RELOAD_DELAY;
                        end
                        else
                            cnt_q = cnt_q + 8'(steps);
                    end
                end
            end
            OP_READ:
            begin
                case (r.reg_sel)
                    SEL_DIV: o.rdata = div_q[15:8];
                    SEL_CNT: o.rdata = cnt_q;
                    SEL_MOD: o.rdata = mod_q;
                    default: o.rdata = ctl_q;
                endcase
            end
            OP_WRITE:
            begin
                rate = ctl_q[1:0];
                case (r.reg_sel)
                    SEL_DIV:
                    begin
                        was = gate_level(div_q, ctl_q, rate);
                        div_q = 16'd0;
                        count_falling(was, gate_level(div_q, ctl_q, rate));
                    end
                    SEL_CNT:
                    begin
                        if (!reloaded_q)
                        begin
                            cnt_q = r.wdata;
                            wait_q = 3'd0;
                        end
                    end
                    SEL_MOD:
                    begin
                        mod_q = r.wdata;
                        if (reloaded_q)
                            cnt_q = r.wdata;
                    end
                    default:
                    begin
                        was = gate_level(div_q, ctl_q, rate);
                        ctl_q = r.wdata;
                        count_falling(was, gate_level(div_q, ctl_q, rate));
                    end
                endcase
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic void note_fail(input string msg);
        fails++;
        if (fails <= 10)
            $display("mismatch at %0t ns: %s", $time, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_q = DIV_RESET;
            cnt_q = 8'd0;
            mod_q = 8'd0;
            ctl_q = CTL_RESET;
            wait_q = 3'd0;
            reloaded_q = 1'b0;
            expected_rsp_q.delete();
            fails = 0;
            checked = 0;
            irqs = 0;
            fail_cnt <= 0;
            pending <= 0;
            rsp_cnt <= 0;
            irq_cnt <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                    note_fail($sformatf("response with nothing expected: rdata %02h irq %0b",
                                        rsp.rdata, rsp.timer_irq));
                else
                begin
                    want = expected_rsp_q.pop_front();
                    checked++;
                    if (want.timer_irq)
                        irqs++;
                    if (want.rdata !== rsp.rdata)
                        note_fail($sformatf("rdata expected %02h got %02h",
                                            want.rdata, rsp.rdata));
                    if (want.timer_irq !== rsp.timer_irq)
                        note_fail($sformatf("timer_irq expected %0b got %0b",
                                            want.timer_irq, rsp.timer_irq));
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(timer_step(req));
            fail_cnt <= fails;
            pending <= expected_rsp_q.size();
            rsp_cnt <= checked;
            irq_cnt <= irqs;
        end
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the divider timer: drives requests and response stalls, gives the verdict.
`timescale 1ns / 1ps
module tb;
    import dtr_pkg::*;

    localparam logic [1:0] OP_NONE         = 2'd3;
    localparam int         CYCLE_LIMIT     = 300000;
    localparam int         HOLD_CYCLES     = 80;
    localparam int         ITEMS_PER_PHASE = 450;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int   fail_cnt;
    int   pending;
    int   rsp_cnt;
    int   irq_cnt;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_tog = 1'b0;
    int   cycle_cnt = 0;
    int   sent = 0;

    divider_timer_with_reload dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    timer_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .fail_cnt  (fail_cnt),
        .pending   (pending),
        .rsp_cnt   (rsp_cnt),
        .irq_cnt   (irq_cnt)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int   hold_left;
        logic seen_tog;
        hold_left = 0;
        seen_tog = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_tog != seen_tog)
            begin
                seen_tog = hold_tog;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] cyc,
                        input logic [1:0] sel, input logic [7:0] wd);
        req_t r;
        r.opcode = op;
        r.cycles = cyc;
        r.reg_sel = sel;
        r.wdata = wd;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (req_stall);
        if (op != OP_NONE)
            sent++;
    endtask

    task automatic drain_all();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] control_byte();
        logic [1:0] rate;
        rate = ($urandom_range(3) != 0) ? RATE_16 : 2'($urandom);
        return {5'($urandom), 1'b1, rate};
    endfunction

    task automatic random_request();
        int         pick;
        logic [1:0] sel;
        logic [7:0] wd;
        pick = $urandom_range(99);
        sel = 2'($urandom);
        wd = 8'($urandom);
        if (sel == SEL_CTL && $urandom_range(3) != 0)
            wd = control_byte();
        else if (sel == SEL_CNT && $urandom_range(1) == 0)
            wd = 8'($urandom_range(255, 240));
        if (pick < 45)
            send(OP_TICK, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(24)),
                 sel, wd);
        else if (pick < 65)
            send(OP_READ, 8'($urandom), sel, wd);
        else if (pick < 95)
            send(OP_WRITE, 8'($urandom), sel, wd);
        else
            send(OP_NONE, 8'($urandom), sel, wd);
    endtask

    // drive the counter to overflow, then poke it around the delayed reload
    task automatic reload_sequence();
        int n;
        send(OP_WRITE, 8'($urandom), SEL_CTL, control_byte());
        send(OP_WRITE, 8'($urandom), SEL_MOD, 8'($urandom));
        send(OP_WRITE, 8'($urandom), SEL_CNT, 8'($urandom_range(255, 251)));
        n = $urandom_range(8, 4);
        repeat (n)
        begin
            case ($urandom_range(3))
                0, 1: send(OP_TICK, ($urandom_range(1) == 0) ? 8'($urandom_range(80, 8))
                                                               : 8'($urandom_range(5)),
                           2'($urandom), 8'($urandom));
                2:    send(OP_WRITE, 8'($urandom), ($urandom_range(1) == 0) ? SEL_CNT : SEL_MOD,
                           8'($urandom));
                default: send(OP_READ, 8'($urandom), 2'($urandom), 8'($urandom));
            endcase
        end
    endtask

    initial
    begin
        int   start;
        logic held;
        held = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_READ,  8'h00, SEL_DIV, 8'h00);
        send(OP_READ,  8'hFF, SEL_CTL, 8'hFF);
        send(OP_READ,  8'h00, SEL_CNT, 8'h00);
        send(OP_READ,  8'h00, SEL_MOD, 8'h00);
        send(OP_TICK,  8'h00, SEL_DIV, 8'h00);
        send(OP_TICK,  8'hFF, SEL_CTL, 8'hFF);
        send(OP_WRITE, 8'h00, SEL_CTL, {5'd0, 1'b1, RATE_16});
        send(OP_WRITE, 8'h00, SEL_MOD, 8'hA5);
        send(OP_WRITE, 8'h00, SEL_CNT, 8'hFF);
        send(OP_TICK,  8'd16, SEL_DIV, 8'h00);
        send(OP_TICK,  8'd1,  SEL_DIV, 8'h00);
        send(OP_TICK,  8'd3,  SEL_DIV, 8'h00);
        send(OP_WRITE, 8'h00, SEL_CNT, 8'h00);
        send(OP_WRITE, 8'h00, SEL_MOD, 8'h3C);
        send(OP_READ,  8'h00, SEL_CNT, 8'h00);
        send(OP_TICK,  8'd12, SEL_DIV, 8'h00);
        send(OP_WRITE, 8'h00, SEL_DIV, 8'h00);
        send(OP_TICK,  8'd8,  SEL_DIV, 8'h00);
        send(OP_WRITE, 8'h00, SEL_CTL, 8'h00);
        send(OP_WRITE, 8'h00, SEL_CTL, 8'hFF);
        send(OP_TICK,  8'hFF, SEL_DIV, 8'h00);
        send(OP_WRITE, 8'h00, SEL_DIV, 8'hFF);
        send(OP_NONE,  8'hFF, SEL_CTL, 8'hFF);
        send(OP_READ,  8'h00, SEL_DIV, 8'h00);
        drain_all();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 16;
                    recv_stall_pct <= 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_stall_pct <= 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
            endcase
            start = sent;
            while (sent - start < ITEMS_PER_PHASE)
            begin
                if (phase == 2 && !held && sent - start >= 100)
                begin
                    hold_tog <= ~hold_tog;
                    held = 1'b1;
                end
                if (phase == 0 && sent - start >= 200 && sent - start < 210)
                    drain_all();
                if ($urandom_range(9) < 4)
                    reload_sequence();
                else
                    random_request();
            end
            drain_all();
        end

        repeat (10) @(posedge clk);
        $display("run: %0d requests over three stall mixes, %0d responses checked, %0d interrupts",
                 sent, rsp_cnt, irq_cnt);
        $display("run: reset values, counter overflow and delayed reload, write edge cases");
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
